>>> hw/rtl/rxrb_pkg.sv
// ---------------------------------------------------------------------------
// rxrb_pkg: shared types and constants for the receive ring buffer
// Command codes, marker byte, empty code and break run limits.
// ---------------------------------------------------------------------------
`default_nettype none

package rxrb_pkg;

   // command codes carried on the request channel
   typedef enum logic [2:0] {
      CMD_PUSH  = 3'd0,
      CMD_POP   = 3'd1,
      CMD_PEEK  = 3'd2,
      CMD_CLEAR = 3'd3,
      CMD_QUERY = 3'd4
   } cmd_type;

   localparam int unsigned BYTE_W = 8;
   localparam int unsigned RUN_W  = 5;

   typedef logic [BYTE_W-1:0] byte_type;
   typedef logic [RUN_W-1:0]  run_type;

   localparam byte_type HASH_CHAR  = 8'h23;
   localparam byte_type EMPTY_CODE = 8'hFF;
   localparam byte_type ZERO_BYTE  = 8'h00;
   localparam run_type  RUN_LIMIT  = 5'd15;
   localparam run_type  RUN_SAT    = 5'd16;

endpackage

`default_nettype wire

>>> hw/rtl/rx_ring_buffer_overwrite_oldest_top.sv
// A result beat appears in the cycle after its request beat is taken.
// Throughput: one request beat per cycle; the single result register stalls
// the request side only while a result waits and the response side stalls.
// The slot memory has one write and one registered read port.
// Reset clears pointers, run counter and the result valid; slot contents
// are not cleared and hold garbage until pushed.
// ---------------------------------------------------------------------------
// rx_ring_buffer_overwrite_oldest_top: receive byte ring buffer
// DEPTH-slot byte ring that drops the oldest byte when full, with pop, peek,
// clear, occupancy query and a '#' run detector for break.
// ---------------------------------------------------------------------------
`default_nettype none

module rx_ring_buffer_overwrite_oldest_top
   import rxrb_pkg::*;
#(
   parameter int unsigned DEPTH = 256
) (
   input  wire logic       clock,
   input  wire logic       reset,
   input  wire logic       req_valid,
   output logic            req_stall,
   input  wire logic [2:0] req_command,
   input  wire logic [7:0] req_rx_byte,
   output logic            rsp_valid,
   input  wire logic       rsp_stall,
   output logic [7:0]      rsp_read_byte,
   output logic [7:0]      rsp_occupancy,
   output logic            rsp_was_empty,
   output logic            rsp_break_detected
);

   localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int unsigned OCC_W = 9;
   localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);
   localparam logic [PTR_W-1:0] PTR_ZERO = '0;
   localparam logic [OCC_W-1:0] OCC_DEPTH = OCC_W'(DEPTH);

   // slot memory
   byte_type mem [DEPTH];

   // state registers
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   run_type          run_ff, run_in;

   // result registers
   logic             rsp_valid_ff, rsp_valid_in;
   logic             rd_sel_ff, rd_sel_in;
   byte_type         rd_fix_ff, rd_fix_in;
   byte_type         rd_data_ff;
   logic [7:0]       occ_ff, occ_in;
   logic             empty_ff, empty_in;
   logic             brk_ff, brk_in;

   logic             accept;
   logic             take;
   logic             is_empty;
   logic             do_read;
   logic [PTR_W-1:0] wr_adv;
   logic [PTR_W-1:0] rd_adv;
   logic [OCC_W-1:0] occ_wide;

   // hold the request side while a result waits on a stalled response
   assign req_stall = rsp_valid_ff & rsp_stall;
   assign accept    = req_valid & ~req_stall;
   assign take      = rsp_valid_ff & ~rsp_stall;

   assign is_empty = (wr_ptr_ff == rd_ptr_ff);
   assign wr_adv   = (wr_ptr_ff == PTR_LAST) ? PTR_ZERO : wr_ptr_ff + 1'b1;
   assign rd_adv   = (rd_ptr_ff == PTR_LAST) ? PTR_ZERO : rd_ptr_ff + 1'b1;

   // next state and result for one request beat
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      run_in    = run_ff;
      rd_sel_in = 1'b0;
      rd_fix_in = ZERO_BYTE;
      empty_in  = 1'b0;
      do_read   = 1'b0;
      case (cmd_type'(req_command))
         CMD_PUSH: begin
            if (req_rx_byte == HASH_CHAR) begin
               if (run_ff < RUN_SAT) begin
                  run_in = run_ff + 1'b1;
               end
            end else begin
               run_in = '0;
            end
            wr_ptr_in = wr_adv;
            // drop the oldest byte when the writer catches the reader
            if (wr_adv == rd_ptr_ff) begin
               rd_ptr_in = rd_adv;
            end
         end
         CMD_POP, CMD_PEEK: begin
            if (is_empty) begin
               rd_fix_in = EMPTY_CODE;
               empty_in  = 1'b1;
            end else begin
               rd_sel_in = 1'b1;
               do_read   = 1'b1;
               if (cmd_type'(req_command) == CMD_POP) begin
                  rd_ptr_in = rd_adv;
               end
            end
         end
         CMD_CLEAR: begin
            wr_ptr_in = PTR_ZERO;
            rd_ptr_in = PTR_ZERO;
         end
         CMD_QUERY: begin
            if (is_empty) begin
               wr_ptr_in = PTR_ZERO;
               rd_ptr_in = PTR_ZERO;
            end
         end
         default: begin
         end
      endcase

      // occupancy after this beat
      if (wr_ptr_in >= rd_ptr_in) begin
         occ_wide = OCC_W'(wr_ptr_in) - OCC_W'(rd_ptr_in);
      end else begin
         occ_wide = OCC_W'(wr_ptr_in) - OCC_W'(rd_ptr_in) + OCC_DEPTH;
      end
      occ_in = occ_wide[7:0];
      brk_in = (run_in > RUN_LIMIT);

      rsp_valid_in = rsp_valid_ff;
      if (accept) begin
         rsp_valid_in = 1'b1;
      end else if (take) begin
         rsp_valid_in = 1'b0;
      end
   end

   // control state
   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff    <= '0;
         rd_ptr_ff    <= '0;
         run_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
         if (accept) begin
            wr_ptr_ff <= wr_ptr_in;
            rd_ptr_ff <= rd_ptr_in;
            run_ff    <= run_in;
         end
      end
   end

   // result payload
   always_ff @(posedge clock) begin
      if (accept) begin
         rd_sel_ff <= rd_sel_in;
         rd_fix_ff <= rd_fix_in;
         occ_ff    <= occ_in;
         empty_ff  <= empty_in;
         brk_ff    <= brk_in;
      end
   end

   // write on push, registered read of the oldest slot on pop or peek
   always_ff @(posedge clock) begin
      if (accept && (cmd_type'(req_command) == CMD_PUSH)) begin
         mem[wr_ptr_ff] <= req_rx_byte;
      end
      if (accept && do_read) begin
         rd_data_ff <= mem[rd_ptr_ff];
      end
   end

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_read_byte      = rd_sel_ff ? rd_data_ff : rd_fix_ff;
   assign rsp_occupancy      = occ_ff;
   assign rsp_was_empty      = empty_ff;
   assign rsp_break_detected = brk_ff;

endmodule

`default_nettype wire

>>> hw/rtl/rxrb_checker.sv
// ---------------------------------------------------------------------------
// rxrb_checker: port-level checks for the receive ring buffer
// Watches request and result beats and flags handshake or result slips.
// ---------------------------------------------------------------------------
`default_nettype none

module rxrb_checker
   import rxrb_pkg::*;
#(
   parameter int unsigned DEPTH = 256
) (
   input wire logic       clock,
   input wire logic       reset,
   input wire logic       req_valid,
   input wire logic       req_stall,
   input wire logic       rsp_valid,
   input wire logic       rsp_stall,
   input wire logic [7:0] rsp_read_byte,
   input wire logic [7:0] rsp_occupancy,
   input wire logic       rsp_was_empty,
   input wire logic       rsp_break_detected
);

   // every taken request beat yields a result beat in the next cycle
   a_rsp_follows: assert property (@(posedge clock) disable iff (reset)
      (req_valid && !req_stall) |=> rsp_valid)
      else $error("result beat missing after request beat");

   // the request side stalls only behind a waiting result
   a_stall_cause: assert property (@(posedge clock) disable iff (reset)
      req_stall |-> (rsp_valid && rsp_stall))
      else $error("request stalled without a waiting result");

   // an empty read reports the empty code
   a_empty_code: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_was_empty) |-> (rsp_read_byte == EMPTY_CODE))
      else $error("empty read without empty code");

   // the ring never reports more than DEPTH-1 bytes
   a_occ_bound: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (32'(rsp_occupancy) < DEPTH))
      else $error("occupancy beyond ring capacity");

   // a stalled result beat holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_stall) |=> (rsp_valid && $stable(rsp_read_byte)
         && $stable(rsp_occupancy) && $stable(rsp_was_empty)
         && $stable(rsp_break_detected)))
      else $error("stalled result beat changed");

endmodule

bind rx_ring_buffer_overwrite_oldest_top rxrb_checker #(.DEPTH(DEPTH)) u_rxrb_checker (
   .clock              (clock),
   .reset              (reset),
   .req_valid          (req_valid),
   .req_stall          (req_stall),
   .rsp_valid          (rsp_valid),
   .rsp_stall          (rsp_stall),
   .rsp_read_byte      (rsp_read_byte),
   .rsp_occupancy      (rsp_occupancy),
   .rsp_was_empty      (rsp_was_empty),
   .rsp_break_detected (rsp_break_detected)
);

`default_nettype wire
